// ----- rtl/core/plru_pkg.sv -----
`default_nettype none

package plru_pkg;

  // Build depth of the slot array.
  localparam int unsigned MAX_SLOTS_DEFAULT = 16;

  // Configuration register indexes and reset values.
  localparam logic REG_TABLE_SIZE_LOG2 = 1'b0;
  localparam logic REG_SLOTS_IN_USE    = 1'b1;
  localparam logic [4:0] TABLE_SIZE_LOG2_RESET = 5'd16;
  localparam logic [4:0] SLOTS_IN_USE_RESET    = 5'd16;

  // Operation codes.
  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  // Result status codes.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_UNALIGNED = 3'd1;
  localparam logic [2:0] ST_ZERO      = 3'd2;
  localparam logic [2:0] ST_NOFREE    = 3'd3;
  localparam logic [2:0] ST_PUTFREE   = 3'd4;
  localparam logic [2:0] ST_OVERFLOW  = 3'd5;

  // Bits of the dividend folded into the start-slot remainder per cycle.
  localparam int unsigned MOD_BITS  = 8;
  localparam int unsigned MOD_STEPS = 64 / MOD_BITS;

  typedef struct packed {
    logic        op;
    logic [63:0] tbl_offset;
    logic [3:0]  slot_index;
  } in_item_t;

  typedef struct packed {
    logic [3:0] slot_out;
    logic       hit;
    logic [2:0] status;
  } result_t;

  typedef struct packed {
    logic [4:0] table_size_log2;
    logic [4:0] slots_in_use;
  } cfg_t;

  // One slot entry as kept in the slot memory.
  typedef struct packed {
    logic [63:0] tag;
    logic [63:0] stamp;
    logic [7:0]  refs;
  } entry_t;

  typedef enum logic [1:0] {
    SLOT_ZERO,
    SLOT_FOUND,
    SLOT_VICTIM,
    SLOT_INDEX
  } slot_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       capture;
    logic       mod_init;
    logic       mod_step;
    logic       scan_init;
    logic       scan_run;
    logic       put_read;
    logic       wr_hit;
    logic       wr_victim;
    logic       wr_put;
    logic       res_set;
    logic [2:0] res_status;
    logic       res_hit;
    slot_sel_t  res_slot;
    logic       out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic op;
    logic zero;
    logic unaligned;
    logic mod_last;
    logic scan_done;
    logic found;
    logic found_full;
    logic have_victim;
    logic put_bad;
  } sts_t;

endpackage

`default_nettype wire

// ----- rtl/core/plru_ram.sv -----
`default_nettype none

module plru_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                          wdata,
  input  wire logic                                      re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/plru_ctrl.sv -----
`default_nettype none

module plru_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  wire logic           out_stall,
  input  wire plru_pkg::sts_t sts,
  output plru_pkg::cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_MOD,
    S_START,
    S_SCAN,
    S_PUT,
    S_FINISH
  } state_t;

  state_t state;
  state_t state_next;

  // A new transaction is taken only while no other is in progress.
  assign in_stall = (state != S_IDLE);

  // Sequencing of commands for each state.
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.op == plru_pkg::OP_PUT) begin
          cmd.put_read = 1'b1;
          state_next   = S_PUT;
        end else if (sts.zero) begin
          cmd.res_set    = 1'b1;
          cmd.res_status = plru_pkg::ST_ZERO;
          cmd.res_slot   = plru_pkg::SLOT_ZERO;
          state_next     = S_FINISH;
        end else if (sts.unaligned) begin
          cmd.res_set    = 1'b1;
          cmd.res_status = plru_pkg::ST_UNALIGNED;
          cmd.res_slot   = plru_pkg::SLOT_ZERO;
          state_next     = S_FINISH;
        end else begin
          cmd.mod_init = 1'b1;
          state_next   = S_MOD;
        end
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (sts.mod_last) begin
          state_next = S_START;
        end
      end
      S_START: begin
        cmd.scan_init = 1'b1;
        state_next    = S_SCAN;
      end
      S_SCAN: begin
        if (!sts.scan_done) begin
          cmd.scan_run = 1'b1;
        end else begin
          cmd.res_set = 1'b1;
          state_next  = S_FINISH;
          if (sts.found) begin
            if (sts.found_full) begin
              cmd.res_status = plru_pkg::ST_OVERFLOW;
              cmd.res_slot   = plru_pkg::SLOT_ZERO;
            end else begin
              cmd.wr_hit     = 1'b1;
              cmd.res_status = plru_pkg::ST_OK;
              cmd.res_hit    = 1'b1;
              cmd.res_slot   = plru_pkg::SLOT_FOUND;
            end
          end else if (sts.have_victim) begin
            cmd.wr_victim  = 1'b1;
            cmd.res_status = plru_pkg::ST_OK;
            cmd.res_slot   = plru_pkg::SLOT_VICTIM;
          end else begin
            cmd.res_status = plru_pkg::ST_NOFREE;
            cmd.res_slot   = plru_pkg::SLOT_ZERO;
          end
        end
      end
      S_PUT: begin
        cmd.res_set  = 1'b1;
        cmd.res_slot = plru_pkg::SLOT_INDEX;
        state_next   = S_FINISH;
        if (sts.put_bad) begin
          cmd.res_status = plru_pkg::ST_PUTFREE;
        end else begin
          cmd.wr_put     = 1'b1;
          cmd.res_status = plru_pkg::ST_OK;
        end
      end
      S_FINISH: begin
        if (!out_valid || !out_stall) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/plru_dpath.sv -----
`default_nettype none

module plru_dpath #(
  parameter int unsigned MAX_SLOTS = plru_pkg::MAX_SLOTS_DEFAULT
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire plru_pkg::cfg_t     cfg,
  input  wire plru_pkg::in_item_t in_data,
  input  wire plru_pkg::cmd_t     cmd,
  output plru_pkg::sts_t          sts,
  output plru_pkg::result_t       out_data
);

  localparam int unsigned AW     = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int unsigned MCW    = (plru_pkg::MOD_STEPS > 1) ? $clog2(plru_pkg::MOD_STEPS) : 1;
  localparam int unsigned EW     = $bits(plru_pkg::entry_t);
  localparam logic [6:0]  MaxS7  = 7'(MAX_SLOTS);

  // Captured transaction.
  logic        req_op;
  logic [63:0] req_offset;
  logic [3:0]  req_index;

  // Start-slot remainder unit.
  logic [63:0]    dvd;
  logic [4:0]     rem;
  logic [MCW-1:0] mod_cnt;
  logic [4:0]     rem_next;

  // Scan bookkeeping.
  logic [AW-1:0] ptr;
  logic [4:0]    issued;
  logic [4:0]    processed;
  logic          rd_pend;
  logic [AW-1:0] rd_ptr;
  logic          rd_vbit;
  logic          found;
  logic [AW-1:0] found_ptr;
  logic [7:0]    found_refs;
  logic [63:0]   found_stamp;
  logic          have_victim;
  logic [AW-1:0] victim_ptr;
  logic [63:0]   best;

  // Slot state kept outside the memory.
  logic [MAX_SLOTS-1:0] slot_valid;
  logic [63:0]          use_clock;
  plru_pkg::result_t    res;

  logic [4:0]       n_eff;
  logic [63:0]      align_mask;
  logic [AW-1:0]    idx_addr;
  logic             idx_oor;
  logic             issue;
  logic             wrap;
  logic [AW-1:0]    ptr_next;
  logic             ram_re;
  logic [AW-1:0]    ram_raddr;
  logic [EW-1:0]    ram_rdata;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  plru_pkg::entry_t wr_entry;
  plru_pkg::entry_t rd_entry;
  logic [3:0]       res_slot;

  // Effective number of slots scanned: zero acts as one, clamp at build depth.
  always_comb begin
    if (cfg.slots_in_use == 5'd0) begin
      n_eff = 5'd1;
    end else if (7'(cfg.slots_in_use) > MaxS7) begin
      n_eff = 5'(MAX_SLOTS);
    end else begin
      n_eff = cfg.slots_in_use;
    end
  end

  assign align_mask = (64'd1 << cfg.table_size_log2) - 64'd1;
  assign idx_addr   = AW'(req_index);
  assign idx_oor    = (7'(req_index) >= MaxS7);

  // Fold MOD_BITS dividend bits into the remainder, most significant first.
  always_comb begin
    logic [5:0] r6;
    r6 = 6'(rem);
    for (int j = 0; j < plru_pkg::MOD_BITS; j++) begin
      r6 = {r6[4:0], dvd[63-j]};
      if (r6 >= 6'(n_eff)) begin
        r6 = r6 - 6'(n_eff);
      end
    end
    rem_next = r6[4:0];
  end

  // Circular scan pointer.
  assign issue    = cmd.scan_run && (issued != n_eff);
  assign wrap     = ((7'(ptr) + 7'd1) == 7'(n_eff));
  assign ptr_next = wrap ? '0 : AW'(ptr + 1'b1);

  // Memory read port: scan reads or the put read.
  assign ram_re    = issue || cmd.put_read;
  assign ram_raddr = cmd.put_read ? idx_addr : ptr;

  // An entry never written reads as all zero.
  assign rd_entry = rd_vbit ? plru_pkg::entry_t'(ram_rdata) : '0;

  // Memory write port: hit, retag or release.
  always_comb begin
    ram_we    = cmd.wr_hit || cmd.wr_victim || cmd.wr_put;
    ram_waddr = idx_addr;
    wr_entry  = rd_entry;
    if (cmd.wr_hit) begin
      ram_waddr      = found_ptr;
      wr_entry.tag   = req_offset;
      wr_entry.stamp = found_stamp;
      wr_entry.refs  = found_refs + 8'd1;
    end else if (cmd.wr_victim) begin
      ram_waddr      = victim_ptr;
      wr_entry.tag   = req_offset;
      wr_entry.stamp = best;
      wr_entry.refs  = 8'd1;
    end else begin
      wr_entry.refs = rd_entry.refs - 8'd1;
      if (rd_entry.refs == 8'd1) begin
        wr_entry.stamp = use_clock + 64'd1;
      end
    end
  end

  plru_ram #(
    .WIDTH(EW),
    .DEPTH(MAX_SLOTS)
  ) u_slot_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(wr_entry),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Slot reported in the result.
  always_comb begin
    case (cmd.res_slot)
      plru_pkg::SLOT_FOUND:  res_slot = 4'(found_ptr);
      plru_pkg::SLOT_VICTIM: res_slot = 4'(victim_ptr);
      plru_pkg::SLOT_INDEX:  res_slot = req_index;
      default:               res_slot = 4'd0;
    endcase
  end

  // Control state: valid bits and the global use clock.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      use_clock  <= '0;
    end else begin
      if (ram_we) begin
        slot_valid[ram_waddr] <= 1'b1;
      end
      if (cmd.wr_put && rd_entry.refs == 8'd1) begin
        use_clock <= use_clock + 64'd1;
      end
    end
  end

  // Transaction capture, remainder unit, scan and result registers.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_op     <= in_data.op;
      req_offset <= in_data.tbl_offset;
      req_index  <= in_data.slot_index;
    end

    if (cmd.mod_init) begin
      dvd     <= {62'(req_offset >> cfg.table_size_log2), 2'b00};
      rem     <= '0;
      mod_cnt <= '0;
    end else if (cmd.mod_step) begin
      dvd     <= dvd << plru_pkg::MOD_BITS;
      rem     <= rem_next;
      mod_cnt <= mod_cnt + 1'b1;
    end

    if (ram_re) begin
      rd_vbit <= slot_valid[ram_raddr];
    end

    if (cmd.scan_init) begin
      ptr         <= AW'(rem);
      issued      <= '0;
      processed   <= '0;
      rd_pend     <= 1'b0;
      found       <= 1'b0;
      have_victim <= 1'b0;
    end else if (cmd.scan_run) begin
      rd_pend <= issue;
      if (issue) begin
        ptr    <= ptr_next;
        rd_ptr <= ptr;
        issued <= issued + 5'd1;
      end
      // Compare the entry read in the previous cycle.
      if (rd_pend && !found) begin
        processed <= processed + 5'd1;
        if (rd_entry.tag == req_offset) begin
          found       <= 1'b1;
          found_ptr   <= rd_ptr;
          found_refs  <= rd_entry.refs;
          found_stamp <= rd_entry.stamp;
        end else if (rd_entry.refs == 8'd0 &&
                     (!have_victim || rd_entry.stamp < best)) begin
          have_victim <= 1'b1;
          victim_ptr  <= rd_ptr;
          best        <= rd_entry.stamp;
        end
      end
    end

    if (cmd.res_set) begin
      res.slot_out <= res_slot;
      res.hit      <= cmd.res_hit;
      res.status   <= cmd.res_status;
    end

    if (cmd.out_load) begin
      out_data <= res;
    end
  end

  // Status toward the controller.
  always_comb begin
    sts.op          = req_op;
    sts.zero        = (req_offset == 64'd0);
    sts.unaligned   = |(req_offset & align_mask);
    sts.mod_last    = (mod_cnt == MCW'(plru_pkg::MOD_STEPS - 1));
    sts.scan_done   = found || (processed == n_eff);
    sts.found       = found;
    sts.found_full  = (found_refs == 8'hFF);
    sts.have_victim = have_victim;
    sts.put_bad     = idx_oor || (rd_entry.refs == 8'd0);
  end

endmodule

`default_nettype wire

// ----- rtl/core/pinned_lru_table_cache.sv -----
`default_nettype none

// Pinned LRU table cache: tracks which table offset each slot holds, how many
// users pin each slot, and when each slot was last released. One transaction
// is processed at a time. A get with a zero or unaligned offset goes from its
// check straight to the output; any other get runs the start-slot remainder
// unit and then the scan, which reads one slot entry per cycle from the slot
// memory with its one write port and one registered read port. A put passes
// through capture, read, update and output. The result sits in an output
// register, so a finished result waiting on a stalled consumer does not hold
// back the next transaction's work, only its delivery. Slot state needs no
// clearing pass after reset: each slot has a valid bit, and a slot never
// written reads as empty.
module pinned_lru_table_cache #(
  parameter int unsigned MAX_SLOTS = plru_pkg::MAX_SLOTS_DEFAULT
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire plru_pkg::in_item_t in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output plru_pkg::result_t       out_data,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  plru_pkg::cfg_t cfg;
  plru_pkg::cmd_t cmd;
  plru_pkg::sts_t sts;
  logic           cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.table_size_log2 <= plru_pkg::TABLE_SIZE_LOG2_RESET;
      cfg.slots_in_use    <= plru_pkg::SLOTS_IN_USE_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == plru_pkg::REG_TABLE_SIZE_LOG2) begin
        cfg.table_size_log2 <= pwdata[4:0];
      end else begin
        cfg.slots_in_use <= pwdata[4:0];
      end
    end
  end

  // Register read back.
  always_comb begin
    unique case (paddr[2])
      plru_pkg::REG_TABLE_SIZE_LOG2: prdata = {27'd0, cfg.table_size_log2};
      plru_pkg::REG_SLOTS_IN_USE:    prdata = {27'd0, cfg.slots_in_use};
      default:                       prdata = 32'd0;
    endcase
  end

  plru_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  plru_dpath #(
    .MAX_SLOTS(MAX_SLOTS)
  ) u_dpath (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .in_data (in_data),
    .cmd     (cmd),
    .sts     (sts),
    .out_data(out_data)
  );

endmodule

`default_nettype wire

// ----- tb/sv/pinned_lru_table_cache_tb.sv -----
`timescale 1ns / 1ps

module pinned_lru_table_cache_tb;

  localparam int SLOTS = plru_pkg::MAX_SLOTS_DEFAULT;
  localparam int SETTLE = 40;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DIR_ROWS = 22;
  localparam int PHASES = 10;
  localparam int PHASE_ITEMS = 22;
  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  // One directed transaction, with its result typed in where it is obvious.
  typedef struct {
    plru_pkg::in_item_t item;
    bit                 typed;
    plru_pkg::result_t  want;
  } dir_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  plru_pkg::in_item_t in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  plru_pkg::result_t  out_data;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  // Shadow of the slot state and configuration.
  logic [63:0] table_tag [SLOTS] = '{default: '0};
  logic [7:0]  pin_count [SLOTS] = '{default: '0};
  logic [63:0] release_stamp [SLOTS] = '{default: '0};
  logic [63:0] release_clock = '0;
  logic [4:0]  cfg_shift = plru_pkg::TABLE_SIZE_LOG2_RESET;
  logic [4:0]  cfg_slots = plru_pkg::SLOTS_IN_USE_RESET;

  plru_pkg::result_t lookup_results[$];
  bit      failed = 1'b0;
  int      cycle_count = 0;
  int      burst_left = 0;
  int      gap_len = 0;
  logic [8:0] stall_cycle = '0;

  dir_row_t dir_rows [DIR_ROWS];

  localparam logic [4:0] PHASE_SHIFT [PHASES] =
    '{5'd21, 5'd12, 5'd0, 5'd31, 5'd10, 5'd14, 5'd9, 5'd20, 5'd16, 5'd9};
  localparam logic [4:0] PHASE_SLOTS [PHASES] =
    '{5'd16, 5'd4, 5'd3, 5'd0, 5'd20, 5'd7, 5'd31, 5'd2, 5'd16, 5'd1};

  pinned_lru_table_cache uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #10 clk = ~clk;

  // Applies one get or put to the shadow state and returns its result.
  function automatic plru_pkg::result_t cache_access(plru_pkg::in_item_t it);
    plru_pkg::result_t r;
    logic [63:0] mask;
    logic [63:0] q;
    logic [63:0] best;
    int          n;
    int          idx;
    int          victim;
    int          k;
    bit          have_victim;
    r = '0;
    if (it.op == plru_pkg::OP_PUT) begin
      r.slot_out = it.slot_index;
      if (pin_count[it.slot_index] == 8'd0) begin
        r.status = plru_pkg::ST_PUTFREE;
      end else begin
        pin_count[it.slot_index] = pin_count[it.slot_index] - 8'd1;
        if (pin_count[it.slot_index] == 8'd0) begin
          release_clock = release_clock + 64'd1;
          release_stamp[it.slot_index] = release_clock;
        end
        r.status = plru_pkg::ST_OK;
      end
      return r;
    end
    n = (cfg_slots == 5'd0) ? 1 : ((int'(cfg_slots) > SLOTS) ? SLOTS : int'(cfg_slots));
    mask = (64'd1 << cfg_shift) - 64'd1;
    if (it.tbl_offset == 64'd0) begin
      r.status = plru_pkg::ST_ZERO;
      return r;
    end
    if ((it.tbl_offset & mask) != 64'd0) begin
      r.status = plru_pkg::ST_UNALIGNED;
      return r;
    end
    // The start slot hash wraps at 64 bits before the remainder.
    q = it.tbl_offset >> cfg_shift;
    q = q << 2;
    idx = int'(q % 64'(n));
    have_victim = 1'b0;
    victim = 0;
    best = '0;
    for (k = 0; k < n; k++) begin
      if (table_tag[idx] == it.tbl_offset) begin
        if (pin_count[idx] == 8'd255) begin
          r.status = plru_pkg::ST_OVERFLOW;
          return r;
        end
        pin_count[idx] = pin_count[idx] + 8'd1;
        r.slot_out = 4'(idx);
        r.hit = 1'b1;
        r.status = plru_pkg::ST_OK;
        return r;
      end
      if (pin_count[idx] == 8'd0 && (!have_victim || release_stamp[idx] < best)) begin
        have_victim = 1'b1;
        best = release_stamp[idx];
        victim = idx;
      end
      idx = (idx + 1 == n) ? 0 : idx + 1;
    end
    if (!have_victim) begin
      r.status = plru_pkg::ST_NOFREE;
      return r;
    end
    table_tag[victim] = it.tbl_offset;
    pin_count[victim] = 8'd1;
    r.slot_out = 4'(victim);
    r.status = plru_pkg::ST_OK;
    return r;
  endfunction

  // Random transaction, weighted toward aligned gets from a small pool of
  // tables and puts on slots that are currently pinned.
  function automatic plru_pkg::in_item_t pick_item();
    plru_pkg::in_item_t it;
    logic [63:0] mask;
    int          held[$];
    int          roll;
    int          s;
    it.op = plru_pkg::OP_GET;
    it.tbl_offset = {$urandom, $urandom};
    it.slot_index = 4'($urandom);
    mask = (64'd1 << cfg_shift) - 64'd1;
    for (s = 0; s < SLOTS; s++) begin
      if (pin_count[s] != 8'd0) held.push_back(s);
    end
    roll = $urandom_range(0, 99);
    if (roll < 40) begin
      it.tbl_offset = 64'($urandom_range(1, 24)) << cfg_shift;
    end else if (roll < 50) begin
      it.tbl_offset = it.tbl_offset & ~mask;
    end else if (roll < 53) begin
      it.tbl_offset = '0;
    end else if (roll >= 56) begin
      it.op = plru_pkg::OP_PUT;
      if (held.size() != 0 && roll < 92) begin
        it.slot_index = 4'(held[$urandom_range(0, held.size() - 1)]);
      end
    end
    return it;
  endfunction

  // Sends one transaction in bursts with random gaps, then records its result.
  task automatic send_item(input plru_pkg::in_item_t it, input bit typed,
                           input plru_pkg::result_t want);
    plru_pkg::result_t r;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap_len = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 8));
      if (gap_len != 0) begin
        in_valid <= 1'b0;
        repeat (gap_len) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    r = cache_access(it);
    lookup_results.push_back(typed ? want : r);
  endtask

  // Drops valid and waits until every pending result has been delivered.
  task automatic drain_all();
    in_valid <= 1'b0;
    burst_left = 0;
    while (lookup_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Register write: setup cycle, then access cycle until pready, then a return
  // to idle so that writes do not run into each other.
  task automatic cfg_write(input logic reg_idx, input logic [4:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_idx, 2'b00};
    pwdata <= {27'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (reg_idx == plru_pkg::REG_TABLE_SIZE_LOG2) begin
      cfg_shift = value;
    end else begin
      cfg_slots = value;
    end
    @(posedge clk);
  endtask

  // Result side: the stall pattern steps through four modes chosen by
  // stall_cycle[8:7], and each accepted transaction is checked against the oldest pending result.
  always @(posedge clk) begin : drain_results
    plru_pkg::result_t want;
    if (rst) begin
      out_stall <= 1'b0;
      stall_cycle <= '0;
    end else begin
      if (out_valid && !out_stall) begin
        if (lookup_results.size() == 0) begin
          $error("unexpected result: slot_out %0d hit %0d status %0d",
                 out_data.slot_out, out_data.hit, out_data.status);
          failed = 1'b1;
        end else begin
          want = lookup_results.pop_front();
          if (out_data.slot_out !== want.slot_out) begin
            $error("slot_out: expected %0d, got %0d", want.slot_out, out_data.slot_out);
            failed = 1'b1;
          end
          if (out_data.hit !== want.hit) begin
            $error("hit: expected %0d, got %0d", want.hit, out_data.hit);
            failed = 1'b1;
          end
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data.status);
            failed = 1'b1;
          end
        end
      end
      stall_cycle <= stall_cycle + 9'd1;
      case (stall_cycle[8:7])
        2'd0: out_stall <= 1'b0;
        2'd1: out_stall <= ($urandom_range(0, 3) == 0);
        2'd2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= ((stall_cycle % 13) < 9);
      endcase
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("pinned_lru_table_cache: mismatch");
      $finish;
    end
  end

  initial begin : stimulus
    int p;
    int i;
    plru_pkg::in_item_t it;
    dir_rows = '{
      '{'{plru_pkg::OP_GET, 64'h0, 4'hF}, 1'b1, '{4'd0, 1'b0, plru_pkg::ST_ZERO}},
      '{'{plru_pkg::OP_GET, 64'h1, 4'h0}, 1'b1, '{4'd0, 1'b0, plru_pkg::ST_UNALIGNED}},
      '{'{plru_pkg::OP_GET, ALL_ONES, 4'h0}, 1'b1, '{4'd0, 1'b0, plru_pkg::ST_UNALIGNED}},
      '{'{plru_pkg::OP_GET, 64'h8000, 4'hA}, 1'b1, '{4'd0, 1'b0, plru_pkg::ST_UNALIGNED}},
      '{'{plru_pkg::OP_PUT, ALL_ONES, 4'hF}, 1'b1, '{4'd15, 1'b0, plru_pkg::ST_PUTFREE}},
      '{'{plru_pkg::OP_PUT, 64'h0, 4'h0}, 1'b1, '{4'd0, 1'b0, plru_pkg::ST_PUTFREE}},
      '{'{plru_pkg::OP_GET, 64'h1_0000, 4'h5}, 1'b1, '{4'd4, 1'b0, plru_pkg::ST_OK}},
      '{'{plru_pkg::OP_GET, 64'h1_0000, 4'hF}, 1'b1, '{4'd4, 1'b1, plru_pkg::ST_OK}},
      '{'{plru_pkg::OP_GET, 64'hFFFF_FFFF_FFFF_0000, 4'h0}, 1'b0, '0},
      '{'{plru_pkg::OP_PUT, 64'h0, 4'h4}, 1'b0, '0},
      '{'{plru_pkg::OP_PUT, ALL_ONES, 4'h4}, 1'b0, '0},
      '{'{plru_pkg::OP_PUT, 64'h0, 4'h4}, 1'b1, '{4'd4, 1'b0, plru_pkg::ST_PUTFREE}},
      '{'{plru_pkg::OP_GET, 64'h2_0000, 4'h0}, 1'b0, '0},
      // A cached table is a hit even after its slot was released.
      '{'{plru_pkg::OP_GET, 64'h1_0000, 4'h0}, 1'b0, '0},
      '{'{plru_pkg::OP_GET, 64'h4_0000, 4'h0}, 1'b0, '0},
      '{'{plru_pkg::OP_GET, 64'h8000_0000_0000_0000, 4'h0}, 1'b0, '0},
      '{'{plru_pkg::OP_PUT, 64'h0, 4'h9}, 1'b0, '0},
      '{'{plru_pkg::OP_PUT, 64'h0, 4'hC}, 1'b0, '0},
      '{'{plru_pkg::OP_GET, 64'h5_0000, 4'h0}, 1'b0, '0},
      '{'{plru_pkg::OP_PUT, 64'h0, 4'h8}, 1'b0, '0},
      '{'{plru_pkg::OP_PUT, 64'h0, 4'h0}, 1'b0, '0},
      '{'{plru_pkg::OP_PUT, 64'h0, 4'h4}, 1'b0, '0}
    };

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed transactions under the reset configuration.
    for (i = 0; i < DIR_ROWS; i++) begin
      send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
    end
    drain_all();

    // Pin one slot until its count saturates, then miss with no free slot.
    cfg_write(plru_pkg::REG_TABLE_SIZE_LOG2, 5'd9);
    cfg_write(plru_pkg::REG_SLOTS_IN_USE, 5'd1);
    it = '{plru_pkg::OP_GET, 64'h200, 4'h0};
    for (i = 0; i < 256; i++) send_item(it, 1'b0, '0);
    it = '{plru_pkg::OP_GET, 64'h400, 4'h3};
    send_item(it, 1'b0, '0);
    drain_all();

    // Random transactions under a series of configurations.
    for (p = 0; p < PHASES; p++) begin
      cfg_write(plru_pkg::REG_TABLE_SIZE_LOG2, PHASE_SHIFT[p]);
      cfg_write(plru_pkg::REG_SLOTS_IN_USE, PHASE_SLOTS[p]);
      for (i = 0; i < PHASE_ITEMS; i++) begin
        send_item(pick_item(), 1'b0, '0);
      end
      drain_all();
    end

    if (!failed) begin
      $display("pinned_lru_table_cache: match");
    end else begin
      $display("pinned_lru_table_cache: mismatch");
    end
    $finish;
  end

endmodule
